// ----- sv/normal_frame_transform_core_assert.svh -----
// assertion macros for the normal frame transform core
// expects clk and rst_n in the including module's scope
`ifndef NORMAL_FRAME_TRANSFORM_CORE_ASSERT_SVH
`define NORMAL_FRAME_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication
`define NFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/nft_pkg.sv -----
// shared types for the normal frame transform core
// no dependencies
package nft_pkg;

  localparam int COMPONENT_WIDTH = 16;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] local_x;
    logic signed [COMPONENT_WIDTH-1:0] local_y;
    logic signed [COMPONENT_WIDTH-1:0] local_z;
    logic signed [COMPONENT_WIDTH-1:0] normal_x;
    logic signed [COMPONENT_WIDTH-1:0] normal_y;
    logic signed [COMPONENT_WIDTH-1:0] normal_z;
  } nft_in_t;

  typedef struct packed {
    logic signed [COMPONENT_WIDTH-1:0] world_x;
    logic signed [COMPONENT_WIDTH-1:0] world_y;
    logic signed [COMPONENT_WIDTH-1:0] world_z;
    logic                              degenerate;
  } nft_out_t;

  typedef struct packed {
    logic en;
    logic valid;
  } nft_ctl_t;

endpackage

// ----- sv/nft_norm.sv -----
// pipelined vector normalize: digit-recurrence square root, then restoring divide
// depends on nft_pkg
module nft_norm
  import nft_pkg::*;
#(
  parameter int IW  = 16,
  parameter int F   = 14,
  parameter int SBW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nft_ctl_t           ctl,
  input  logic [2:0][IW-1:0] in_vec,
  input  logic [SBW-1:0]     in_side,
  output logic               out_valid,
  output logic [2:0][F+1:0]  out_vec,
  output logic [SBW-1:0]     out_side
);

  localparam int RW  = IW;
  localparam int SW  = 2 * IW;
  localparam int RMW = IW + 3;
  localparam int QW  = F + 1;
  localparam int NW  = IW + F + 1;
  localparam int OW  = F + 2;

  logic               f_v_r;
  logic [SBW-1:0]     f_side_r;
  logic [2:0][IW-1:0] f_mag_r;
  logic [2:0]         f_neg_r;
  logic [2:0][IW-1:0] f_mag_nxt;

  logic               q_v_r;
  logic [SBW-1:0]     q_side_r;
  logic [2:0][SW-1:0] q_sq_r;
  logic [2:0][IW-1:0] q_mag_r;
  logic [2:0]         q_neg_r;

  logic               sr_v_r    [0:RW];
  logic [SBW-1:0]     sr_side_r [0:RW];
  logic [2:0][IW-1:0] sr_mag_r  [0:RW];
  logic [2:0]         sr_neg_r  [0:RW];
  logic [RMW-1:0]     sr_rem_r  [0:RW];
  logic [RW-1:0]      sr_root_r [0:RW];
  logic [SW-1:0]      sr_s_r    [0:RW];
  logic [RMW-1:0]     sr_rem_nxt  [1:RW];
  logic [RW-1:0]      sr_root_nxt [1:RW];
  logic [SW-1:0]      sr_s_nxt    [1:RW];

  logic               dv_v_r    [0:QW];
  logic [SBW-1:0]     dv_side_r [0:QW];
  logic [2:0]         dv_neg_r  [0:QW];
  logic               dv_zero_r [0:QW];
  logic [RW-1:0]      dv_div_r  [0:QW];
  logic [2:0][RW-1:0] dv_rem_r  [0:QW];
  logic [2:0][QW-1:0] dv_low_r  [0:QW];
  logic [2:0][QW-1:0] dv_q_r    [0:QW];
  logic [2:0][RW-1:0] dv_rem_nxt [1:QW];
  logic [2:0][QW-1:0] dv_low_nxt [1:QW];
  logic [2:0][QW-1:0] dv_q_nxt   [1:QW];
  logic [2:0][RW-1:0] dv0_rem_nxt;
  logic [2:0][QW-1:0] dv0_low_nxt;

  logic               o_v_r;
  logic [SBW-1:0]     o_side_r;
  logic [2:0][OW-1:0] o_vec_r;
  logic [2:0][OW-1:0] o_vec_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_mag_nxt[i] = in_vec[i][IW-1] ? IW'(~in_vec[i] + IW'(1)) : in_vec[i];
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [RMW-1:0] rsh;
    logic [RMW-1:0] trial;
    for (int k = 0; k < RW; k++) begin
      rsh   = {sr_rem_r[k][RMW-3:0], sr_s_r[k][SW-1 -: 2]};
      trial = {1'b0, sr_root_r[k], 2'b01};
      if (rsh >= trial) begin
        sr_rem_nxt[k+1]  = rsh - trial;
        sr_root_nxt[k+1] = {sr_root_r[k][RW-2:0], 1'b1};
      end else begin
        sr_rem_nxt[k+1]  = rsh;
        sr_root_nxt[k+1] = {sr_root_r[k][RW-2:0], 1'b0};
      end
      sr_s_nxt[k+1] = {sr_s_r[k][SW-3:0], 2'b00};
    end
  end

  // dividend with half-divisor rounding term
  always_comb begin
    logic [NW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = NW'({sr_mag_r[RW][i], {F{1'b0}}}) + NW'(sr_root_r[RW] >> 1);
      dv0_rem_nxt[i] = num[NW-1:QW];
      dv0_low_nxt[i] = num[QW-1:0];
    end
  end

  // restoring divide, one quotient bit per stage per lane
  always_comb begin
    logic [RW:0] dsh;
    logic [RW:0] dsub;
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        dsh  = {dv_rem_r[k][i], dv_low_r[k][i][QW-1]};
        dsub = dsh - {1'b0, dv_div_r[k]};
        if (dsh >= {1'b0, dv_div_r[k]}) begin
          dv_rem_nxt[k+1][i] = dsub[RW-1:0];
          dv_q_nxt[k+1][i]   = {dv_q_r[k][i][QW-2:0], 1'b1};
        end else begin
          dv_rem_nxt[k+1][i] = dsh[RW-1:0];
          dv_q_nxt[k+1][i]   = {dv_q_r[k][i][QW-2:0], 1'b0};
        end
        dv_low_nxt[k+1][i] = {dv_low_r[k][i][QW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[QW]) begin
        o_vec_nxt[i] = '0;
      end else if (dv_neg_r[QW][i]) begin
        o_vec_nxt[i] = OW'(0) - OW'(dv_q_r[QW][i]);
      end else begin
        o_vec_nxt[i] = OW'(dv_q_r[QW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
      q_v_r <= 1'b0;
      o_v_r <= 1'b0;
      for (int k = 0; k <= RW; k++) sr_v_r[k] <= 1'b0;
      for (int k = 0; k <= QW; k++) dv_v_r[k] <= 1'b0;
    end else if (ctl.en) begin
      f_v_r     <= ctl.valid;
      q_v_r     <= f_v_r;
      sr_v_r[0] <= q_v_r;
      for (int k = 1; k <= RW; k++) sr_v_r[k] <= sr_v_r[k-1];
      dv_v_r[0] <= sr_v_r[RW];
      for (int k = 1; k <= QW; k++) dv_v_r[k] <= dv_v_r[k-1];
      o_v_r     <= dv_v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      f_side_r <= in_side;
      f_mag_r  <= f_mag_nxt;
      for (int i = 0; i < 3; i++) f_neg_r[i] <= in_vec[i][IW-1];

      q_side_r <= f_side_r;
      q_mag_r  <= f_mag_r;
      q_neg_r  <= f_neg_r;
      for (int i = 0; i < 3; i++) q_sq_r[i] <= SW'(f_mag_r[i]) * SW'(f_mag_r[i]);

      sr_side_r[0] <= q_side_r;
      sr_mag_r[0]  <= q_mag_r;
      sr_neg_r[0]  <= q_neg_r;
      sr_rem_r[0]  <= '0;
      sr_root_r[0] <= '0;
      sr_s_r[0]    <= q_sq_r[0] + q_sq_r[1] + q_sq_r[2];
      for (int k = 1; k <= RW; k++) begin
        sr_side_r[k] <= sr_side_r[k-1];
        sr_mag_r[k]  <= sr_mag_r[k-1];
        sr_neg_r[k]  <= sr_neg_r[k-1];
        sr_rem_r[k]  <= sr_rem_nxt[k];
        sr_root_r[k] <= sr_root_nxt[k];
        sr_s_r[k]    <= sr_s_nxt[k];
      end

      dv_side_r[0] <= sr_side_r[RW];
      dv_neg_r[0]  <= sr_neg_r[RW];
      dv_zero_r[0] <= (sr_root_r[RW] == '0);
      dv_div_r[0]  <= sr_root_r[RW];
      dv_rem_r[0]  <= dv0_rem_nxt;
      dv_low_r[0]  <= dv0_low_nxt;
      dv_q_r[0]    <= '0;
      for (int k = 1; k <= QW; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
        dv_neg_r[k]  <= dv_neg_r[k-1];
        dv_zero_r[k] <= dv_zero_r[k-1];
        dv_div_r[k]  <= dv_div_r[k-1];
        dv_rem_r[k]  <= dv_rem_nxt[k];
        dv_low_r[k]  <= dv_low_nxt[k];
        dv_q_r[k]    <= dv_q_nxt[k];
      end

      o_side_r <= dv_side_r[QW];
      o_vec_r  <= o_vec_nxt;
    end
  end

  assign out_valid = o_v_r;
  assign out_vec   = o_vec_r;
  assign out_side  = o_side_r;

endmodule

// ----- sv/nft_cross.sv -----
// two-stage fixed-point cross product t x n with round-half-away shift
// depends on nft_pkg
module nft_cross
  import nft_pkg::*;
#(
  parameter int F   = 14,
  parameter int SBW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nft_ctl_t          ctl,
  input  logic [2:0][F+1:0] in_t,
  input  logic [2:0][F+1:0] in_n,
  input  logic [SBW-1:0]    in_side,
  output logic              out_valid,
  output logic [2:0][F+2:0] out_vec,
  output logic [SBW-1:0]    out_side
);

  localparam int PW = 2 * F + 4;
  localparam int DW = 2 * F + 5;
  localparam int BW = F + 3;

  logic               p_v_r;
  logic [SBW-1:0]     p_side_r;
  logic [5:0][PW-1:0] p_r;
  logic               c_v_r;
  logic [SBW-1:0]     c_side_r;
  logic [2:0][BW-1:0] c_vec_r;
  logic [2:0][BW-1:0] c_vec_nxt;

  always_comb begin
    logic signed [DW-1:0] d;
    logic [DW-1:0]        dm;
    logic [DW-1:0]        rm;
    for (int i = 0; i < 3; i++) begin
      d  = DW'($signed(p_r[2*i])) - DW'($signed(p_r[2*i+1]));
      dm = d[DW-1] ? DW'(-d) : DW'(d);
      rm = (dm + (DW'(1) << (F - 1))) >> F;
      c_vec_nxt[i] = d[DW-1] ? BW'(DW'(0) - rm) : BW'(rm);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (ctl.en) begin
      p_v_r <= ctl.valid;
      c_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_side_r <= in_side;
      p_r[0]   <= PW'($signed(in_t[1]) * $signed(in_n[2]));
      p_r[1]   <= PW'($signed(in_t[2]) * $signed(in_n[1]));
      p_r[2]   <= PW'($signed(in_t[2]) * $signed(in_n[0]));
      p_r[3]   <= PW'($signed(in_t[0]) * $signed(in_n[2]));
      p_r[4]   <= PW'($signed(in_t[0]) * $signed(in_n[1]));
      p_r[5]   <= PW'($signed(in_t[1]) * $signed(in_n[0]));
      c_side_r <= p_side_r;
      c_vec_r  <= c_vec_nxt;
    end
  end

  assign out_valid = c_v_r;
  assign out_vec   = c_vec_r;
  assign out_side  = c_side_r;

endmodule

// ----- sv/nft_blend.sv -----
// final basis blend: nine products, then rounded, saturated sums into the output word
// depends on nft_pkg
module nft_blend
  import nft_pkg::*;
#(
  parameter int F = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nft_ctl_t                      ctl,
  input  logic [2:0][COMPONENT_WIDTH-1:0] in_loc,
  input  logic [2:0][F+2:0]             in_b,
  input  logic [2:0][F+1:0]             in_t,
  input  logic [2:0][F+1:0]             in_n,
  input  logic                          in_deg,
  output logic                          out_valid,
  output nft_out_t                      out_word
);

  localparam int CW = COMPONENT_WIDTH;
  localparam int PW = CW + F + 3;
  localparam int AW = PW + 2;
  localparam logic [AW-1:0] SAT_HI = AW'((64'(1) << (CW - 1)) - 64'(1));

  logic                    p_v_r;
  logic                    p_deg_r;
  logic [2:0][2:0][PW-1:0] p_r;
  logic                    o_v_r;
  nft_out_t                o_word_r;
  logic [2:0][CW-1:0]      w_nxt;

  always_comb begin
    logic signed [AW-1:0] acc;
    logic [AW-1:0]        am;
    logic [AW-1:0]        rm;
    for (int i = 0; i < 3; i++) begin
      acc = AW'($signed(p_r[i][0])) + AW'($signed(p_r[i][1])) + AW'($signed(p_r[i][2]));
      am  = acc[AW-1] ? AW'(-acc) : AW'(acc);
      rm  = (am + (AW'(1) << (F - 1))) >> F;
      if (p_deg_r) begin
        w_nxt[i] = '0;
      end else if (!acc[AW-1]) begin
        w_nxt[i] = (rm > SAT_HI) ? SAT_HI[CW-1:0] : rm[CW-1:0];
      end else begin
        w_nxt[i] = (rm > SAT_HI + AW'(1)) ? {1'b1, {(CW-1){1'b0}}} : CW'(0) - rm[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (ctl.en) begin
      p_v_r <= ctl.valid;
      o_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p_deg_r <= in_deg;
      for (int i = 0; i < 3; i++) begin
        p_r[i][0] <= PW'($signed(in_loc[0]) * $signed(in_b[i]));
        p_r[i][1] <= PW'($signed(in_loc[1]) * $signed(in_t[i]));
        p_r[i][2] <= PW'($signed(in_loc[2]) * $signed(in_n[i]));
      end
      o_word_r.world_x    <= w_nxt[0];
      o_word_r.world_y    <= w_nxt[1];
      o_word_r.world_z    <= w_nxt[2];
      o_word_r.degenerate <= p_deg_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_word  = o_word_r;

endmodule

// ----- sv/normal_frame_transform_core.sv -----
// normal frame transform core: local direction to world frame around a surface normal
// depends on nft_pkg, nft_norm, nft_cross, nft_blend and the assertion macro header
//
//   port group | dir | word
//   in_*       | in  | nft_in_t, local direction and surface normal
//   out_*      | out | nft_out_t, world direction and degenerate flag
//
// one word enters per cycle while in_stall is low; three normalize units each hold a
// square-root and a divide chain of one bit per stage
// the whole pipeline advances together; in_stall is high only while a finished word
// waits at the output under out_stall, and nothing moves meanwhile, bubbles included
// synchronous active-low reset clears the valid bits only
`include "normal_frame_transform_core_assert.svh"

module normal_frame_transform_core
  import nft_pkg::*;
#(
  parameter int FRACTION_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  nft_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output nft_out_t out_word
);

  localparam int F  = FRACTION_BITS;
  localparam int CW = COMPONENT_WIDTH;
  localparam int OW = F + 2;
  localparam int S1 = 3 * CW + 1;
  localparam int S2 = S1 + 3 * OW;
  localparam int S3 = S2 + 3 * OW;
  localparam int HW = F + 6;

  logic               en;
  nft_ctl_t           c_in;
  nft_ctl_t           c_t;
  nft_ctl_t           c_x;
  nft_ctl_t           c_b;
  nft_ctl_t           c_f;
  logic [2:0][CW-1:0] nrm_in;
  logic [S1-1:0]      side1_in;

  logic               n_v;
  logic [2:0][OW-1:0] n_vec;
  logic [S1-1:0]      n_side;

  logic               h_v_r;
  logic [2:0][OW-1:0] h_t_r;
  logic [S2-1:0]      h_side_r;
  logic [2:0][OW-1:0] h_t_nxt;
  logic [OW-1:0]      nx_mag;
  logic               use_y;

  logic               t_v;
  logic [2:0][OW-1:0] t_vec;
  logic [S2-1:0]      t_side;

  logic               b_raw_v;
  logic [2:0][F+2:0]  b_raw;
  logic [S3-1:0]      b_raw_side;

  logic               b_v;
  logic [2:0][OW-1:0] b_vec;
  logic [S3-1:0]      b_side;

  logic [2:0][CW-1:0] f_loc;
  logic               f_deg;
  logic [2:0][OW-1:0] f_n;
  logic [2:0][OW-1:0] f_t;
  logic [2:0][F+2:0]  f_b;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign c_in     = '{en: en, valid: in_valid};
  assign c_t      = '{en: en, valid: h_v_r};
  assign c_x      = '{en: en, valid: t_v};
  assign c_b      = '{en: en, valid: b_raw_v};
  assign c_f      = '{en: en, valid: b_v};

  assign nrm_in   = {in_word.normal_z, in_word.normal_y, in_word.normal_x};
  assign side1_in = {(nrm_in == '0), in_word.local_z, in_word.local_y, in_word.local_x};

  nft_norm #(.IW(CW), .F(F), .SBW(S1)) u_norm_n (
    .clk(clk), .rst_n(rst_n), .ctl(c_in),
    .in_vec(nrm_in), .in_side(side1_in),
    .out_valid(n_v), .out_vec(n_vec), .out_side(n_side)
  );

  // helper axis pick and tangent direction
  always_comb begin
    nx_mag = n_vec[0][OW-1] ? OW'(0) - n_vec[0] : n_vec[0];
    use_y  = (HW'(nx_mag) * HW'(10)) > (HW'(9) << F);
    if (use_y) begin
      h_t_nxt[0] = n_vec[2];
      h_t_nxt[1] = '0;
      h_t_nxt[2] = OW'(0) - n_vec[0];
    end else begin
      h_t_nxt[0] = '0;
      h_t_nxt[1] = OW'(0) - n_vec[2];
      h_t_nxt[2] = n_vec[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_t_r    <= h_t_nxt;
      h_side_r <= {n_vec, n_side};
    end
  end

  nft_norm #(.IW(OW), .F(F), .SBW(S2)) u_norm_t (
    .clk(clk), .rst_n(rst_n), .ctl(c_t),
    .in_vec(h_t_r), .in_side(h_side_r),
    .out_valid(t_v), .out_vec(t_vec), .out_side(t_side)
  );

  nft_cross #(.F(F), .SBW(S3)) u_cross (
    .clk(clk), .rst_n(rst_n), .ctl(c_x),
    .in_t(t_vec), .in_n(t_side[S2-1:S1]), .in_side({t_vec, t_side}),
    .out_valid(b_raw_v), .out_vec(b_raw), .out_side(b_raw_side)
  );

  nft_norm #(.IW(F + 3), .F(F), .SBW(S3)) u_norm_b (
    .clk(clk), .rst_n(rst_n), .ctl(c_b),
    .in_vec(b_raw), .in_side(b_raw_side),
    .out_valid(b_v), .out_vec(b_vec), .out_side(b_side)
  );

  assign f_loc = b_side[3*CW-1:0];
  assign f_deg = b_side[S1-1];
  assign f_n   = b_side[S2-1:S1];
  assign f_t   = b_side[S3-1:S2];
  always_comb begin
    for (int i = 0; i < 3; i++) f_b[i] = {b_vec[i][OW-1], b_vec[i]};
  end

  nft_blend #(.F(F)) u_blend (
    .clk(clk), .rst_n(rst_n), .ctl(c_f),
    .in_loc(f_loc), .in_b(f_b), .in_t(f_t), .in_n(f_n), .in_deg(f_deg),
    .out_valid(out_valid), .out_word(out_word)
  );

  `NFT_ASSERT_IMP(a_deg_zero, out_valid && out_word.degenerate, out_word.world_x == '0 && out_word.world_y == '0 && out_word.world_z == '0, "degenerate word with nonzero direction")
  `NFT_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall, "input stalled without a held output word")
  `NFT_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")

endmodule
